/* rtl/crlffc_pkg.sv */
// ----------------------------------------------------------------------------
// crlffc_pkg
// Shared types, constants and helpers for the line-ending normalizing byte
// FIFO with XON/XOFF flow control.
// ----------------------------------------------------------------------------
package crlffc_pkg;

   // Storage geometry. The ring holds at most FIFO_DEPTH-1 bytes.
   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   localparam ptr_type PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
   localparam ptr_type FILL_FULL  = PTR_W'(FIFO_DEPTH - 1);
   localparam ptr_type FILL_PAIR  = PTR_W'(FIFO_DEPTH - 2);
   localparam ptr_type XOFF_LEVEL = PTR_W'((FIFO_DEPTH * 3) / 4);
   localparam ptr_type XON_LEVEL  = PTR_W'(FIFO_DEPTH / 4);

   // Field widths of the word interface.
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 16;
   localparam int FILL_OUT_W = 8;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_XOFF = 8'h13;
   localparam logic [BYTE_W-1:0] CH_XON  = 8'h11;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

   // Opcodes of an input word.
   localparam logic OP_HOST = 1'b0;
   localparam logic OP_SLOT = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXT_MODE   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLOW_ENABLE = 1'b1;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Classified kind of an input word.
   typedef enum logic [2:0] {
      CMD_RAW,
      CMD_CR,
      CMD_LF,
      CMD_CHAR,
      CMD_SLOT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [BYTE_W-1:0]  data_byte;
      logic               block_end;
      logic               printer_accepts;
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic                  accepted;
      logic [COUNT_W-1:0]    accepted_in_block;
      logic                  print_valid;
      logic [BYTE_W-1:0]     print_byte;
      logic                  flow_valid;
      logic [BYTE_W-1:0]     flow_byte;
      logic                  paused;
      logic [FILL_OUT_W-1:0] fill_level;
   } rsp_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_LF,
      ST_READ
   } back_state_type;

   // Ring pointer increment with wrap at the last entry.
   function automatic ptr_type ptr_next(ptr_type p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

/* rtl/crlffc_ram.sv */
// ----------------------------------------------------------------------------
// crlffc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module crlffc_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/crlffc_front.sv */
// ----------------------------------------------------------------------------
// crlffc_front
// Accepts input words, classifies them by line-ending role and holds them in
// a short command queue for the back end.
// ----------------------------------------------------------------------------
module crlffc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          text_mode,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [crlffc_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                          req_block_end,
   input  logic                          req_printer_accepts,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output crlffc_pkg::cmd_type           cmd
);
   import crlffc_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   cmd_type             queue_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             new_cmd;
   logic                push;
   logic                pop;

   // Classify the incoming word.
   always_comb begin
      new_cmd.data_byte       = req_data_byte;
      new_cmd.block_end       = req_block_end;
      new_cmd.printer_accepts = req_printer_accepts;
      if (req_opcode == OP_SLOT) begin
         new_cmd.kind = CMD_SLOT;
      end else if (!text_mode) begin
         new_cmd.kind = CMD_RAW;
      end else if (req_data_byte == CH_CR) begin
         new_cmd.kind = CMD_CR;
      end else if (req_data_byte == CH_LF) begin
         new_cmd.kind = CMD_LF;
      end else begin
         new_cmd.kind = CMD_CHAR;
      end
   end

   // Queue bookkeeping.
   always_comb begin
      req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
      cmd_valid = (count_ff != '0);
      cmd       = queue_ff[rd_ptr_ff];
      push      = req_valid && req_ready;
      pop       = cmd_valid && cmd_ready;

      queue_in  = queue_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;

      if (push) begin
         queue_in[wr_ptr_ff] = new_cmd;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Queue pointers and fill.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries carry payload only.
   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

endmodule

/* rtl/crlffc_back.sv */
// ----------------------------------------------------------------------------
// crlffc_back
// Executes classified commands against the byte ring: stores, swallows or
// pops bytes, tracks the block count and decides XON/XOFF.
// ----------------------------------------------------------------------------
module crlffc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                flow_enable,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  crlffc_pkg::cmd_type cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output crlffc_pkg::rsp_type rsp
);
   import crlffc_pkg::*;

   back_state_type       state_ff, state_in;
   ptr_type              wr_ptr_ff, wr_ptr_in;
   ptr_type              rd_ptr_ff, rd_ptr_in;
   ptr_type              fill_ff, fill_in;
   ptr_type              lf_addr_ff, lf_addr_in;
   logic                 cr_seen_ff, cr_seen_in;
   logic                 xoff_ff, xoff_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 ram_we;
   ptr_type              ram_waddr;
   logic [BYTE_W-1:0]    ram_wdata;
   logic                 ram_re;
   logic [BYTE_W-1:0]    ram_rdata;

   logic                 out_free;
   logic                 go;
   logic                 push_one;
   logic                 push_two;
   logic                 took;
   logic                 do_read;
   logic                 paused;
   logic                 flow_valid;
   logic [BYTE_W-1:0]    flow_byte;
   ptr_type              fill_new;
   logic [COUNT_W-1:0]   count_new;
   ptr_type              ptr_span;

   crlffc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Decide what the head command does to the ring.
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      cmd_ready = (state_ff == ST_IDLE) && out_free;
      go        = cmd_valid && cmd_ready;
      push_one  = 1'b0;
      push_two  = 1'b0;
      took      = 1'b0;
      do_read   = 1'b0;
      paused    = 1'b0;
      cr_seen_in = cr_seen_ff;

      if (go) begin
         case (cmd.kind)
            CMD_SLOT: begin
               if (fill_ff != '0) begin
                  if (cmd.printer_accepts) begin
                     do_read = 1'b1;
                  end else begin
                     paused = 1'b1;
                  end
               end
            end
            CMD_RAW: begin
               if (fill_ff != FILL_FULL) begin
                  push_one = 1'b1;
                  took     = 1'b1;
               end
            end
            CMD_CHAR: begin
               if (fill_ff != FILL_FULL) begin
                  push_one   = 1'b1;
                  took       = 1'b1;
                  cr_seen_in = 1'b0;
               end
            end
            CMD_CR: begin
               if (fill_ff < FILL_PAIR) begin
                  push_two   = 1'b1;
                  took       = 1'b1;
                  cr_seen_in = 1'b1;
               end
            end
            CMD_LF: begin
               // A line feed right after a carriage return is already stored.
               if (cr_seen_ff) begin
                  took       = 1'b1;
                  cr_seen_in = 1'b0;
               end else if (fill_ff < FILL_PAIR) begin
                  push_two = 1'b1;
                  took     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Fill after this command, block count and flow control decision.
   always_comb begin
      if (push_one) begin
         fill_new = fill_ff + PTR_W'(1);
      end else if (push_two) begin
         fill_new = fill_ff + PTR_W'(2);
      end else if (do_read) begin
         fill_new = fill_ff - PTR_W'(1);
      end else begin
         fill_new = fill_ff;
      end

      count_new = (took && (count_ff != COUNT_MAX)) ? count_ff + COUNT_W'(1) : count_ff;

      flow_valid = 1'b0;
      flow_byte  = '0;
      xoff_in    = xoff_ff;
      if (go && flow_enable) begin
         if (paused) begin
            if (!xoff_ff) begin
               xoff_in    = 1'b1;
               flow_valid = 1'b1;
               flow_byte  = CH_XOFF;
            end
         end else if (!xoff_ff && (fill_new > XOFF_LEVEL)) begin
            xoff_in    = 1'b1;
            flow_valid = 1'b1;
            flow_byte  = CH_XOFF;
         end else if (xoff_ff && (fill_new < XON_LEVEL)) begin
            xoff_in    = 1'b0;
            flow_valid = 1'b1;
            flow_byte  = CH_XON;
         end
      end
   end

   // Sequencer: ring writes, the read wait and the result register.
   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      lf_addr_in   = lf_addr_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = wr_ptr_ff;
      ram_wdata    = cmd.data_byte;
      ram_re       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               fill_in = fill_new;
               if (cmd.kind != CMD_SLOT) begin
                  count_in = cmd.block_end ? '0 : count_new;
               end
               if (push_one) begin
                  ram_we    = 1'b1;
                  wr_ptr_in = ptr_next(wr_ptr_ff);
               end
               if (push_two) begin
                  ram_we     = 1'b1;
                  ram_wdata  = CH_CR;
                  lf_addr_in = ptr_next(wr_ptr_ff);
                  wr_ptr_in  = ptr_next(ptr_next(wr_ptr_ff));
                  state_in   = ST_PUSH_LF;
               end
               if (do_read) begin
                  ram_re    = 1'b1;
                  rd_ptr_in = ptr_next(rd_ptr_ff);
                  state_in  = ST_READ;
               end

               rsp_in.accepted          = took;
               rsp_in.accepted_in_block = count_new;
               rsp_in.print_valid       = do_read;
               rsp_in.print_byte        = '0;
               rsp_in.flow_valid        = flow_valid;
               rsp_in.flow_byte         = flow_byte;
               rsp_in.paused            = paused;
               rsp_in.fill_level        = FILL_OUT_W'(fill_new);
               rsp_valid_in             = !do_read;
            end
         end
         ST_PUSH_LF: begin
            ram_we    = 1'b1;
            ram_waddr = lf_addr_ff;
            ram_wdata = CH_LF;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            rsp_in.print_byte = ram_rdata;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         cr_seen_ff   <= 1'b0;
         xoff_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         cr_seen_ff   <= cr_seen_in;
         xoff_ff      <= xoff_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lf_addr_ff <= lf_addr_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Distance between the ring pointers, for checking the fill count.
   assign ptr_span = (wr_ptr_ff >= rd_ptr_ff) ? (wr_ptr_ff - rd_ptr_ff)
                   : (wr_ptr_ff + PTR_W'(FIFO_DEPTH) - rd_ptr_ff);

   // The fill count always matches the pointer distance.
   assert property (@(posedge clock) disable iff (reset) fill_ff == ptr_span)
      else $error("fill count disagrees with ring pointers");

   // A command is taken only when the result register can be reloaded.
   assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |-> (!rsp_valid_ff || rsp_ready))
      else $error("command taken while result word is stalled");

   // While a pop waits for read data, no result word is shown.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("result shown before popped byte arrived");

   // A popped byte and a pause never appear in the same result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.print_valid && rsp_ff.paused))
      else $error("result reports both pop and pause");

endmodule

/* rtl/crlf_normalizing_fifo_flow_control.sv */
// ----------------------------------------------------------------------------
// crlf_normalizing_fifo_flow_control
// A word goes through the command queue, then the result register; a pop
// waits in ST_READ for the registered memory read before its result is shown.
// Throughput: one word per cycle while results are taken; a CR LF pair
// waits in ST_PUSH_LF (single write port), a pop in ST_READ (registered read).
// Reset clears pointers, flags and the block count and sets text_mode and
// flow_enable to 1; the byte memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module crlf_normalizing_fifo_flow_control (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [crlffc_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                              req_block_end,
   input  logic                              req_printer_accepts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic [crlffc_pkg::COUNT_W-1:0]    rsp_accepted_in_block,
   output logic                              rsp_print_valid,
   output logic [crlffc_pkg::BYTE_W-1:0]     rsp_print_byte,
   output logic                              rsp_flow_valid,
   output logic [crlffc_pkg::BYTE_W-1:0]     rsp_flow_byte,
   output logic                              rsp_paused,
   output logic [crlffc_pkg::FILL_OUT_W-1:0] rsp_fill_level,
   input  logic                              csr_we,
   input  logic [crlffc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [crlffc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import crlffc_pkg::*;

   logic    text_mode_ff, text_mode_in;
   logic    flow_enable_ff, flow_enable_in;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;
   rsp_type rsp;

   // Configuration register writes.
   always_comb begin
      text_mode_in   = text_mode_ff;
      flow_enable_in = flow_enable_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_TEXT_MODE:   text_mode_in   = csr_wdata[0];
            CSR_FLOW_ENABLE: flow_enable_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff   <= 1'b1;
         flow_enable_ff <= 1'b1;
      end else begin
         text_mode_ff   <= text_mode_in;
         flow_enable_ff <= flow_enable_in;
      end
   end

   // Front end: accept and classify words.
   crlffc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .text_mode           (text_mode_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_data_byte       (req_data_byte),
      .req_block_end       (req_block_end),
      .req_printer_accepts (req_printer_accepts),
      .cmd_valid           (cmd_valid),
      .cmd_ready           (cmd_ready),
      .cmd                 (cmd)
   );

   // Back end: ring, counters and flow control.
   crlffc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .flow_enable (flow_enable_ff),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   // Result word onto its ports.
   assign rsp_accepted          = rsp.accepted;
   assign rsp_accepted_in_block = rsp.accepted_in_block;
   assign rsp_print_valid       = rsp.print_valid;
   assign rsp_print_byte        = rsp.print_byte;
   assign rsp_flow_valid        = rsp.flow_valid;
   assign rsp_flow_byte         = rsp.flow_byte;
   assign rsp_paused            = rsp.paused;
   assign rsp_fill_level        = rsp.fill_level;

endmodule
